@@ rtl/evfo_pkg.sv @@
// ----------------------------------------------------------------------------
// evfo_pkg: shared types and constants for the event FIFO with overflow hole
// Holds the request and result structs, command and result codes, and the
// control and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package evfo_pkg;

	localparam int CAPACITY = 64;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int CFG_DW   = 20;

	localparam logic [2:0] CMD_EVENT   = 3'd0;
	localparam logic [2:0] CMD_POP     = 3'd1;
	localparam logic [2:0] CMD_DROP_N  = 3'd2;
	localparam logic [2:0] CMD_DROP_TO = 3'd3;
	localparam logic [2:0] CMD_END     = 3'd4;

	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_INTERVAL  = 1'b1;

	localparam logic [15:0] THR_RESET = 16'd1;
	localparam logic [19:0] IVL_RESET = 20'd10000;

	typedef enum logic [3:0] {
		K_QUEUED    = 4'd0,
		K_DROPPED   = 4'd1,
		K_HOLE      = 4'd2,
		K_POPPED    = 4'd3,
		K_EMPTY     = 4'd4,
		K_DROP_DONE = 4'd5,
		K_NOTICE    = 4'd6,
		K_HOLE_PEND = 4'd7,
		K_END_CLEAN = 4'd8
	} kind_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] event_id;
		logic [31:0] payload;
		logic [16:0] drop_count;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic        entry_is_hole;
		logic [31:0] entry_id;
		logic [31:0] entry_value;
		logic [31:0] range_begin;
		logic [31:0] range_end;
		logic [16:0] amount;
		logic [16:0] free_slots;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic push2;
		logic scan_step;
		logic sel1;
	} ctrl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       fill_zero;
		logic       scan_hit;
		logic       scan_more;
		logic       push2;
		logic       two_res;
	} sts_t;

endpackage

@@ rtl/evfo_dp.sv @@
// ----------------------------------------------------------------------------
// evfo_dp: datapath of the event FIFO
// Entry memories, FIFO pointers, drop bookkeeping, configuration and the two
// result registers of one request.
// ----------------------------------------------------------------------------
module evfo_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  evfo_pkg::req_t            req,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [evfo_pkg::CFG_DW-1:0] cfg_data,
	input  evfo_pkg::ctrl_t           ctrl,
	output evfo_pkg::sts_t            sts,
	output evfo_pkg::rsp_t            rsp
);
	import evfo_pkg::*;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW:0]   CAP_X = (CW+1)'(CAPACITY);

	function automatic logic [AW-1:0] slot_of(logic [AW-1:0] h, logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(h) + {1'b0, off};
		if (s >= CAP_X) begin
			s = s - CAP_X;
		end
		return s[AW-1:0];
	endfunction

	logic [31:0] id_mem [CAPACITY];
	logic [32:0] val_mem [CAPACITY];
	logic [31:0] rd_id_q;
	logic [32:0] rd_val_q;

	req_t          in_q;
	logic [15:0]   thr_q;
	logic [19:0]   ivl_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [31:0]   pend_q, dstart_q, lseen_q;
	logic [19:0]   nc_q;
	logic [CW-1:0] scan_q;
	rsp_t          r0_q, r1_q;
	logic          two_q;

	logic [CW-1:0] free, take2, rd_off, rm, fill_n, fill_fin;
	logic [15:0]   thr_e;
	logic [19:0]   ivl_e, nc_n;
	logic [20:0]   cnt_inc;
	logic          room;
	logic [AW-1:0] rd_addr, wr_addr, head_n;
	logic [31:0]   pend_n, dstart_n, lseen_n, pinc, hid_ev, hid_end;
	rsp_t          r0, r1;
	logic          two, we_x, we;
	logic [31:0]   w_id, wid_m;
	logic [32:0]   w_val, wval_m;
	logic [16:0]   fs;

	assign free    = CAP_C - fill_q;
	assign thr_e   = (thr_q == 16'd0) ? 16'd1 : thr_q;
	assign ivl_e   = (ivl_q == 20'd0) ? 20'd1 : ivl_q;
	assign room    = 17'(free) > 17'(thr_e);
	assign take2   = (in_q.drop_count > 17'(fill_q)) ? fill_q : in_q.drop_count[CW-1:0];
	assign pinc    = (pend_q == 32'hFFFF_FFFF) ? pend_q : pend_q + 32'd1;
	assign cnt_inc = {1'b0, nc_q} + 21'd1;
	assign hid_ev  = in_q.event_id - 32'd1;
	assign hid_end = lseen_q - 32'd1;

	always_comb begin
		case (in_q.command)
			CMD_DROP_N:  rd_off = (take2 == '0) ? '0 : take2 - CW'(1);
			CMD_DROP_TO: rd_off = scan_q;
			default:     rd_off = '0;
		endcase
	end

	assign rd_addr = slot_of(head_q, rd_off);
	assign wr_addr = slot_of(head_q, fill_q);

	assign sts.cmd       = in_q.command;
	assign sts.fill_zero = (fill_q == '0);
	assign sts.scan_hit  = (rd_id_q <= in_q.event_id);
	assign sts.scan_more = ({1'b0, scan_q} + (CW+1)'(1)) < {1'b0, fill_q};
	assign sts.push2     = (in_q.command == CMD_EVENT) && (pend_q != '0) && room;
	assign sts.two_res   = two_q;

	// Work out the whole step of one request from the held request and state.
	always_comb begin
		r0       = '0;
		r1       = '0;
		two      = 1'b0;
		we_x     = 1'b0;
		w_id     = in_q.event_id;
		w_val    = {1'b0, in_q.payload};
		rm       = '0;
		pend_n   = pend_q;
		dstart_n = dstart_q;
		nc_n     = nc_q;
		lseen_n  = lseen_q;
		fill_n   = fill_q;
		fill_fin = fill_q;
		case (in_q.command)
			CMD_EVENT: begin
				lseen_n = in_q.event_id;
				if (pend_q != '0) begin
					if (room) begin
						we_x     = 1'b1;
						w_id     = hid_ev;
						w_val    = {1'b1, pend_q};
						r0.kind  = K_HOLE;
						r0.entry_is_hole = 1'b1;
						r0.entry_id      = hid_ev;
						r0.entry_value   = pend_q;
						r0.range_begin   = dstart_q;
						r0.range_end     = hid_ev;
						r1.kind          = K_QUEUED;
						r1.entry_id      = in_q.event_id;
						r1.entry_value   = in_q.payload;
						two      = 1'b1;
						pend_n   = '0;
						fill_n   = fill_q + CW'(1);
						fill_fin = fill_q + CW'(2);
					end else begin
						pend_n         = pinc;
						r0.kind        = K_DROPPED;
						r0.entry_id    = in_q.event_id;
						r0.entry_value = pinc;
						if (cnt_inc >= {1'b0, ivl_e}) begin
							nc_n           = '0;
							two            = 1'b1;
							r1.kind        = K_NOTICE;
							r1.entry_id    = hid_ev;
							r1.entry_value = pinc;
							r1.range_begin = dstart_q;
							r1.range_end   = hid_ev;
						end else begin
							nc_n = cnt_inc[19:0];
						end
					end
				end else if (free == '0) begin
					dstart_n       = in_q.event_id;
					pend_n         = 32'd1;
					nc_n           = (ivl_e == 20'd1) ? 20'd0 : 20'd1;
					r0.kind        = K_DROPPED;
					r0.entry_id    = in_q.event_id;
					r0.entry_value = 32'd1;
				end else begin
					we_x           = 1'b1;
					r0.kind        = K_QUEUED;
					r0.entry_id    = in_q.event_id;
					r0.entry_value = in_q.payload;
					fill_n         = fill_q + CW'(1);
					fill_fin       = fill_q + CW'(1);
				end
			end
			CMD_POP: begin
				if (fill_q == '0) begin
					r0.kind = K_EMPTY;
				end else begin
					r0.kind          = K_POPPED;
					r0.entry_is_hole = rd_val_q[32];
					r0.entry_id      = rd_id_q;
					r0.entry_value   = rd_val_q[31:0];
					rm               = CW'(1);
				end
			end
			CMD_DROP_N: begin
				r0.kind     = K_DROP_DONE;
				r0.entry_id = (take2 == '0) ? 32'd0 : rd_id_q;
				r0.amount   = 17'(take2);
				rm          = take2;
			end
			CMD_DROP_TO: begin
				r0.kind     = K_DROP_DONE;
				r0.entry_id = (scan_q == '0) ? 32'd0 : in_q.event_id;
				r0.amount   = 17'(scan_q);
				rm          = scan_q;
			end
			CMD_END: begin
				if (pend_q == '0) begin
					r0.kind = K_END_CLEAN;
				end else if (room) begin
					we_x     = 1'b1;
					w_id     = hid_end;
					w_val    = {1'b1, pend_q};
					r0.kind  = K_HOLE;
					r0.entry_is_hole = 1'b1;
					r0.entry_id      = hid_end;
					r0.entry_value   = pend_q;
					r0.range_begin   = dstart_q;
					r0.range_end     = hid_end;
					pend_n   = '0;
					fill_n   = fill_q + CW'(1);
					fill_fin = fill_q + CW'(1);
				end else begin
					r0.kind = K_HOLE_PEND;
				end
			end
			default: begin
				r0.kind = K_EMPTY;
			end
		endcase
		if (rm != '0) begin
			fill_n   = fill_q - rm;
			fill_fin = fill_q - rm;
		end
		fs            = 17'(CAP_C - fill_fin);
		r0.free_slots = fs;
		r1.free_slots = fs;
		r0.last       = !two;
		r1.last       = 1'b1;
	end

	assign head_n = slot_of(head_q, rm);
	assign we     = (ctrl.exec && we_x) || ctrl.push2;
	assign wid_m  = ctrl.push2 ? in_q.event_id : w_id;
	assign wval_m = ctrl.push2 ? {1'b0, in_q.payload} : w_val;

	always_ff @(posedge clk) begin
		if (we) begin
			id_mem[wr_addr]  <= wid_m;
			val_mem[wr_addr] <= wval_m;
		end
		rd_id_q  <= id_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			in_q <= req;
		end
		if (ctrl.exec) begin
			r0_q <= r0;
			r1_q <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			ivl_q    <= IVL_RESET;
			head_q   <= '0;
			fill_q   <= '0;
			pend_q   <= '0;
			dstart_q <= '0;
			nc_q     <= '0;
			lseen_q  <= 32'd1;
			scan_q   <= '0;
			two_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == CFG_THRESHOLD) begin
					thr_q <= cfg_data[15:0];
				end else begin
					ivl_q <= cfg_data;
				end
			end
			if (ctrl.latch) begin
				scan_q <= '0;
			end else if (ctrl.scan_step) begin
				scan_q <= scan_q + CW'(1);
			end
			if (ctrl.exec) begin
				head_q   <= head_n;
				fill_q   <= fill_n;
				pend_q   <= pend_n;
				dstart_q <= dstart_n;
				nc_q     <= nc_n;
				lseen_q  <= lseen_n;
				two_q    <= two;
			end else if (ctrl.push2) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	assign rsp = ctrl.sel1 ? r1_q : r0_q;

endmodule

@@ rtl/evfo_ctrl.sv @@
// ----------------------------------------------------------------------------
// evfo_ctrl: sequencer of the event FIFO
// Steps one request through decode, the leading-run scan, execution, the
// second write of a hole-plus-event and delivery of one or two results.
// ----------------------------------------------------------------------------
module evfo_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  evfo_pkg::sts_t  sts,
	output evfo_pkg::ctrl_t ctrl
);
	import evfo_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SCAN_CMP, S_SCAN_RD, S_EXEC, S_WR2, S_OUT0, S_OUT1
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (req_valid) state_q <= S_DECODE;
				S_DECODE: begin
					if (sts.cmd == CMD_DROP_TO && !sts.fill_zero) state_q <= S_SCAN_CMP;
					else state_q <= S_EXEC;
				end
				S_SCAN_CMP: begin
					if (sts.scan_hit && sts.scan_more) state_q <= S_SCAN_RD;
					else state_q <= S_EXEC;
				end
				S_SCAN_RD: state_q <= S_SCAN_CMP;
				S_EXEC:    state_q <= sts.push2 ? S_WR2 : S_OUT0;
				S_WR2:     state_q <= S_OUT0;
				S_OUT0: begin
					if (rsp_ready) state_q <= sts.two_res ? S_OUT1 : S_IDLE;
				end
				S_OUT1: if (rsp_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready      = (state_q == S_IDLE);
	assign rsp_valid      = (state_q == S_OUT0) || (state_q == S_OUT1);
	assign ctrl.latch     = (state_q == S_IDLE) && req_valid;
	assign ctrl.exec      = (state_q == S_EXEC);
	assign ctrl.push2     = (state_q == S_WR2);
	assign ctrl.scan_step = (state_q == S_SCAN_CMP) && sts.scan_hit;
	assign ctrl.sel1      = (state_q == S_OUT1);

endmodule

@@ rtl/event_fifo_overflow_hole_summary.sv @@
// ----------------------------------------------------------------------------
// event_fifo_overflow_hole_summary: bounded event FIFO with overflow hole
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one request: an arriving
//   event, a pop, a drop of the k oldest entries, a drop of the leading run
//   of ids up to a target, or a stream end. Each request yields one or two
//   results on the rsp channel (rsp_valid/rsp_ready/rsp); rsp.last marks the
//   final one. cfg_write/cfg_index/cfg_data set the hole threshold (index 0)
//   and the notice interval (index 1) while no request is in flight.
//   One request is handled at a time: after acceptance it is decoded and
//   executed, and then its first result is offered. A drop-up-to-id
//   request compares the leading entries one memory read at a time, with a
//   read state between compares, and stops at a larger id or when it
//   empties the FIFO; on an empty FIFO it skips the compares.
//   An event that queues a hole ahead of itself passes through a separate
//   state for the second write through the single memory write port.
//   Reset empties the FIFO and clears drop state at once (the entry memories
//   are not cleared; only occupied entries are ever read). While the
//   receiver stalls, hold the result and accept no new request.
// ----------------------------------------------------------------------------
module event_fifo_overflow_hole_summary (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  evfo_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output evfo_pkg::rsp_t              rsp,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [evfo_pkg::CFG_DW-1:0] cfg_data
);
	import evfo_pkg::*;

	ctrl_t ctrl;
	sts_t  sts;

	// Sequence each request through its steps.
	evfo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.ctrl      (ctrl)
	);

	// Hold entries, pointers, drop bookkeeping and results.
	evfo_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.sts       (sts),
		.rsp       (rsp)
	);

	// A request is never taken while a result is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_valid && req_ready && rsp_valid))
		else $error("request accepted while result pending");

	// After acceptance the block is not ready in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("ready right after acceptance");

	// Free slot count never exceeds capacity.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.free_slots <= 17'(CAPACITY)))
		else $error("free slots above capacity");

	// Single-result kinds always close the request.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.kind == K_EMPTY || rsp.kind == K_DROP_DONE
			|| rsp.kind == K_POPPED)) |-> rsp.last)
		else $error("single-result kind without last");

endmodule
